// File: hdl/crc64x_pkg.sv
// package: constants, queue entry type and xor-network tables for the crc-64 block
`timescale 1ns / 1ps
package crc64x_pkg;

  // reflected ecma-182 polynomial
  localparam logic [63:0] CRC_POLY = 64'hC96C5795D7870F42;

  // widest beat the data ports can carry, and the default lane width
  localparam int MAX_LANE_BYTES = 16;
  localparam int LANE_BYTES_DEF = 16;

  localparam int CRC_W   = 64;
  localparam int DATA_W  = 8 * MAX_LANE_BYTES;
  localparam int COUNT_W = 5;

  // entry handed from the front end to the back end
  typedef struct packed {
    logic [CRC_W-1:0]   fold;
    logic [COUNT_W-1:0] count;
    logic               first;
    logic               last;
  } crc_entry_t;

  // column tables: one column per input bit
  typedef logic [CRC_W-1:0][CRC_W-1:0]              adv_mat_t;
  typedef logic [MAX_LANE_BYTES:0][CRC_W-1:0][CRC_W-1:0] adv_tab_t;
  typedef logic [DATA_W-1:0][CRC_W-1:0]             fold_mat_t;

  // advance a remainder by a number of zero bytes, bit by bit (elaboration only)
  function automatic logic [CRC_W-1:0] crc_adv(logic [CRC_W-1:0] v, int nbytes);
    logic [CRC_W-1:0] r;
    r = v;
    for (int i = 0; i < 8 * nbytes; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // remainder advance matrices for 0 to 16 bytes
  function automatic adv_tab_t build_adv_tab();
    adv_tab_t t;
    for (int n = 0; n <= MAX_LANE_BYTES; n++) begin
      for (int i = 0; i < CRC_W; i++) begin
        t[n][i] = crc_adv(64'(1) << i, n);
      end
    end
    return t;
  endfunction

  // contribution of each data bit of a full beat folded from a zero remainder
  function automatic fold_mat_t build_fold_mat();
    fold_mat_t m;
    for (int k = 0; k < MAX_LANE_BYTES; k++) begin
      for (int b = 0; b < 8; b++) begin
        m[8*k+b] = crc_adv(64'(1) << b, MAX_LANE_BYTES - k);
      end
    end
    return m;
  endfunction

  localparam adv_tab_t  ADV_TAB  = build_adv_tab();
  localparam fold_mat_t FOLD_MAT = build_fold_mat();

endpackage

// File: hdl/crc64x_in_if.sv
// interface: input beat channel with valid/ready handshake
`timescale 1ns / 1ps
interface crc64x_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_lo;
  logic [63:0] data_hi;
  logic [4:0]  byte_count;
  logic        first;
  logic        last;

  modport source (output valid, data_lo, data_hi, byte_count, first, last, input ready);
  modport sink   (input valid, data_lo, data_hi, byte_count, first, last, output ready);
endinterface

// File: hdl/crc64x_out_if.sv
// interface: result channel with valid/ready handshake
`timescale 1ns / 1ps
interface crc64x_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] crc;

  modport source (output valid, crc, input ready);
  modport sink   (input valid, crc, output ready);
endinterface

// File: hdl/crc64_ecma_reflected_block_top.sv
// top level: reflected crc-64 (xz form) over 16-byte beats
//
//   channel   dir  handshake             payload
//   in_i      in   valid/ready           data_lo, data_hi, byte_count, first, last
//   out_o     out  valid/ready           crc
//   cfg       in   cfg_we_i, no stall    cfg_wdata_i (seed)
//
// one beat per cycle unless results stall; a last beat's crc is queued, then registered.
// the front end folds the beat's data into a queue entry in the accept cycle; the back
// end advances the remainder through a constant xor table selected by byte count.
// reset clears seed, remainder, queue and result valid; no clearing pass.
// a stalled result holds the back end only for last beats; the two-entry queue then fills.
`timescale 1ns / 1ps
module crc64_ecma_reflected_block_top #(
  parameter int LANE_BYTES = crc64x_pkg::LANE_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,
  crc64x_in_if.sink     in_i,
  crc64x_out_if.source  out_o
);
  import crc64x_pkg::*;

  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  crc_entry_t push_data, pop_data;

  // classify and pre-fold each beat
  crc64x_front #(
    .LANE_BYTES (LANE_BYTES)
  ) u_front (
    .in_i         (in_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  // decoupling queue
  crc64x_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // remainder update and result
  crc64x_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

// File: hdl/crc64x_front.sv
// front end: count saturation, beat alignment and data-only fold
`timescale 1ns / 1ps
module crc64x_front #(
  parameter int LANE_BYTES = crc64x_pkg::LANE_BYTES_DEF
) (
  crc64x_in_if.sink                 in_i,
  input  logic                      push_ready_i,
  output logic                      push_valid_o,
  output crc64x_pkg::crc_entry_t    push_data_o
);
  import crc64x_pkg::*;

  localparam logic [COUNT_W-1:0] LIMIT     = COUNT_W'(LANE_BYTES);
  localparam logic [COUNT_W-1:0] FULL_BEAT = COUNT_W'(MAX_LANE_BYTES);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] pad;
  logic [DATA_W-1:0]  aligned;
  logic [CRC_W-1:0]   fold;

  // clamp the byte count to the lane width
  always_comb begin
    if (in_i.byte_count > LIMIT) begin
      count = LIMIT;
    end else begin
      count = in_i.byte_count;
    end
  end

  // move valid bytes to the top of the beat; leading zeros leave a zero remainder unchanged
  assign pad     = FULL_BEAT - count;
  assign aligned = {in_i.data_hi, in_i.data_lo} << {pad, 3'b000};

  // data-only fold through the constant column table
  always_comb begin
    fold = '0;
    for (int j = 0; j < DATA_W; j++) begin
      if (aligned[j]) begin
        fold = fold ^ FOLD_MAT[j];
      end
    end
  end

  // handshake straight through to the queue
  assign in_i.ready         = push_ready_i;
  assign push_valid_o       = in_i.valid;
  assign push_data_o.fold   = fold;
  assign push_data_o.count  = count;
  assign push_data_o.first  = in_i.first;
  assign push_data_o.last   = in_i.last;

endmodule

// File: hdl/crc64x_queue.sv
// two-entry queue decoupling the front end from the back end
`timescale 1ns / 1ps
module crc64x_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_valid_i,
  output logic                   push_ready_o,
  input  crc64x_pkg::crc_entry_t push_data_i,
  output logic                   pop_valid_o,
  input  logic                   pop_ready_i,
  output crc64x_pkg::crc_entry_t pop_data_o
);
  import crc64x_pkg::*;

  crc_entry_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/crc64x_back.sv
// back end: seed register, running remainder and result register
`timescale 1ns / 1ps
module crc64x_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [63:0]            cfg_wdata_i,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  crc64x_pkg::crc_entry_t pop_data_i,
  crc64x_out_if.source           out_o
);
  import crc64x_pkg::*;

  logic [CRC_W-1:0] seed_q;
  logic [CRC_W-1:0] rem_q, rem_d;
  logic [CRC_W-1:0] crc_q, crc_d;
  logic             out_valid_q, out_valid_d;
  logic [CRC_W-1:0] base;
  logic [CRC_W-1:0] advanced;
  logic [CRC_W-1:0] rem_new;
  logic             pop;

  // a non-final entry never needs the result register
  assign pop_ready_o = !pop_data_i.last || !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i && pop_ready_o;

  // starting remainder, advanced over the entry's byte count
  assign base = pop_data_i.first ? ~seed_q : rem_q;

  always_comb begin
    advanced = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (base[i]) begin
        advanced = advanced ^ ADV_TAB[pop_data_i.count][i];
      end
    end
  end

  assign rem_new = advanced ^ pop_data_i.fold;

  // remainder and result register update
  always_comb begin
    rem_d       = rem_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      rem_d = rem_new;
      if (pop_data_i.last) begin
        crc_d       = ~rem_new;
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.crc   = crc_q;

endmodule

// File: tb/tb.sv
// testbench: checks the crc-64/xz beat engine against a bit-serial model of the checksum
`timescale 1ns / 1ps
module tb;
  import crc64x_pkg::*;

  // one row of the directed table; known rows carry a hand-checked crc
  typedef struct packed {
    logic        wr_seed;
    logic [63:0] seed_val;
    logic        is_first;
    logic        is_last;
    logic [4:0]  cnt;
    logic [63:0] lo;
    logic [63:0] hi;
    logic        known;
    logic [63:0] known_crc;
  } beat_row_t;

  localparam int DIR_ROWS = 22;
  localparam int RAND_BEATS = 1150;
  localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] CHECK_CRC = 64'h995D_C9BB_DF19_39FA;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [63:0] cfg_wdata;

  crc64x_in_if  in_if ();
  crc64x_out_if out_if ();

  crc64_ecma_reflected_block_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // model state and bookkeeping
  logic [63:0] crc_expect_q[$];
  logic [63:0] model_seed;
  logic [63:0] model_rem;
  logic [63:0] last_crc;
  logic [63:0] crc_exp;
  beat_row_t   dir_tab [DIR_ROWS];
  bit          calm;
  int          fail_count;
  int          beats_sent;
  int          crc_checked;
  int          seed_writes;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit, far above the slowest legal run
  initial begin
    #(10_000_000);
    $display("timeout: %0d crc results still pending", crc_expect_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // fold up to LANE_BYTES_DEF bytes into a reflected remainder, one bit at a time
  function automatic logic [63:0] fold_beat(logic [63:0] rem, logic [63:0] lo,
                                            logic [63:0] hi, logic [4:0] cnt);
    logic [127:0] bytes;
    logic [63:0]  r;
    int           n;
    bytes = {hi, lo};
    r = rem;
    n = (cnt > LANE_BYTES_DEF) ? LANE_BYTES_DEF : int'(cnt);
    for (int i = 0; i < n; i++) begin
      r = r ^ {56'd0, bytes[8*i +: 8]};
      for (int b = 0; b < 8; b++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
    end
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // byte count: full beats and empty beats often, oversized counts sometimes
  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 5'd0;
    if (r < 40) return 5'd16;
    if (r < 46) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(1, 15));
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic note_fail(input string what, input logic [63:0] exp_v, input logic [63:0] act_v);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    end
  endtask

  // drive one beat, wait for its transaction, then update the model
  task automatic push_beat(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] cnt,
                           input bit is_first, input bit is_last,
                           input bit known, input logic [63:0] known_crc);
    int gap;
    in_if.valid      <= 1'b1;
    in_if.data_lo    <= lo;
    in_if.data_hi    <= hi;
    in_if.byte_count <= cnt;
    in_if.first      <= is_first;
    in_if.last       <= is_last;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
    model_rem = fold_beat(is_first ? ~model_seed : model_rem, lo, hi, cnt);
    if (is_last) begin
      last_crc = ~model_rem;
      crc_expect_q.push_back(known ? known_crc : ~model_rem);
    end
    gap = pick_idle();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain the pipe, then load a new seed
  task automatic load_seed(input logic [63:0] v);
    in_if.valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    model_seed = v;
    seed_writes++;
  endtask

  // result side: random back-pressure
  initial begin
    int n;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      n = pick_idle();
      if (n == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end
    end
  end

  // compare each crc transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      crc_checked++;
      if (crc_expect_q.size() == 0) begin
        note_fail("crc with no pending message", 64'd0, out_if.crc);
      end else begin
        crc_exp = crc_expect_q.pop_front();
        if (crc_exp !== out_if.crc) begin
          note_fail("crc mismatch", crc_exp, out_if.crc);
        end
      end
    end
  end

  // stimulus
  initial begin
    int kind;
    int len;
    logic [63:0] v;

    // directed rows: seed write flag, seed, first, last, count, data lo/hi, known crc
    dir_tab = '{
      // no first since reset: remainder is zero, nothing folded
      '{0, 64'd0, 0, 1, 5'd0, 64'd0, 64'd0, 1, ONES},
      // empty message returns the seed
      '{0, 64'd0, 1, 1, 5'd0, 64'd0, 64'd0, 1, 64'd0},
      // standard check string in one beat
      '{0, 64'd0, 1, 1, 5'd9, 64'h3837_3635_3433_3231, 64'h39, 1, CHECK_CRC},
      // same string over two beats
      '{0, 64'd0, 1, 0, 5'd4, 64'h3433_3231, 64'd0, 0, 64'd0},
      '{0, 64'd0, 0, 1, 5'd5, 64'h39_3837_3635, 64'd0, 1, CHECK_CRC},
      // remainder kept after last
      '{0, 64'd0, 0, 1, 5'd0, ONES, ONES, 1, CHECK_CRC},
      // full beat, then counts above the lane width
      '{0, 64'd0, 1, 1, 5'd16, ONES, ONES, 0, 64'd0},
      '{0, 64'd0, 1, 1, 5'd31, ONES, ONES, 0, 64'd0},
      '{0, 64'd0, 1, 1, 5'd17, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 0, 64'd0},
      '{0, 64'd0, 1, 1, 5'd16, 64'd0, 64'd0, 0, 64'd0},
      // middle beat with no marks, then a closing beat
      '{0, 64'd0, 0, 0, 5'd16, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 0, 64'd0},
      '{0, 64'd0, 0, 1, 5'd8, 64'h8000_0000_0000_0001, 64'd0, 0, 64'd0},
      // message abandoned by a new first
      '{0, 64'd0, 1, 0, 5'd15, 64'hDEAD_BEEF_0BAD_F00D, 64'h00C0_FFEE_1234_5678, 0, 64'd0},
      '{0, 64'd0, 1, 1, 5'd1, 64'hFF, 64'd0, 0, 64'd0},
      // all-ones seed, empty message
      '{1, ONES, 1, 1, 5'd0, 64'd0, 64'd0, 1, ONES},
      // seed written mid-message: the open message keeps its remainder
      '{0, 64'd0, 1, 0, 5'd3, 64'h63_6261, 64'd0, 0, 64'd0},
      '{1, 64'h0123_4567_89AB_CDEF, 0, 1, 5'd2, 64'h6564, 64'd0, 0, 64'd0},
      '{0, 64'd0, 1, 1, 5'd0, 64'd0, 64'd0, 1, 64'h0123_4567_89AB_CDEF},
      // single-bit edges of the lanes
      '{1, 64'd0, 1, 1, 5'd16, 64'h8000_0000_0000_0080, 64'h0100_0000_0000_8000, 0, 64'd0},
      '{0, 64'd0, 1, 1, 5'd16, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, 64'd0},
      // empty beats without first
      '{0, 64'd0, 0, 0, 5'd0, 64'd0, 64'd0, 0, 64'd0},
      '{0, 64'd0, 0, 1, 5'd0, 64'd0, 64'd0, 0, 64'd0}
    };

    calm             = 1'b0;
    fail_count       = 0;
    beats_sent       = 0;
    crc_checked      = 0;
    seed_writes      = 0;
    model_seed       = 64'd0;
    model_rem        = 64'd0;
    last_crc         = 64'd0;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 64'd0;
    in_if.valid      <= 1'b0;
    in_if.data_lo    <= 64'd0;
    in_if.data_hi    <= 64'd0;
    in_if.byte_count <= 5'd0;
    in_if.first      <= 1'b0;
    in_if.last       <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].wr_seed) load_seed(dir_tab[i].seed_val);
      push_beat(dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].cnt, dir_tab[i].is_first,
                dir_tab[i].is_last, dir_tab[i].known, dir_tab[i].known_crc);
    end

    // random messages, with some stray and abandoned beats and seed changes
    while (beats_sent < DIR_ROWS + RAND_BEATS) begin
      calm = ((beats_sent / 200) % 3) == 1;
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          push_beat(rand_word(), rand_word(), pick_count(), k == 0, k == len - 1, 0, 64'd0);
        end
      end else if (kind < 88) begin
        push_beat(rand_word(), rand_word(), pick_count(), 0, $urandom_range(0, 1), 0, 64'd0);
      end else if (kind < 95) begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          push_beat(rand_word(), rand_word(), pick_count(), k == 0, 0, 0, 64'd0);
        end
      end else begin
        case ($urandom_range(0, 3))
          0: v = 64'd0;
          1: v = ONES;
          2: v = last_crc;  // continue the last checksum
          default: v = rand_word();
        endcase
        load_seed(v);
      end
    end

    // drain
    in_if.valid <= 1'b0;
    while (crc_expect_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d beats, checked %0d crc results", beats_sent, crc_checked);
    $display("seed loaded %0d times, %0d mismatches", seed_writes, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
